>>> sv/dmks_pkg.sv
// shared types and constants of the density matrix kraus step unit
// no dependencies
package dmks_pkg;

  localparam int REG_COUNT = 8;
  localparam int ADDR_W = 6;
  localparam int FRAC_BITS = 30;
  localparam int EXP_BIAS = 28;

  localparam logic [2:0] REG_NOJUMP_M00 = 3'd0;
  localparam logic [2:0] REG_NOJUMP_M11 = 3'd3;
  localparam logic [2:0] REG_JUMP_M00 = 3'd4;

  localparam logic [63:0] OP_ONE = 64'h0000_0001_0000_0000;
  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

  typedef logic [REG_COUNT-1:0][63:0] op_bank_t;

  typedef struct packed {
    logic       start;
    logic       mac;
    logic       norm;
    logic       lz;
    logic       shift;
    logic       capture;
    logic       pass;
    logic [2:0] idx;
    logic [2:0] lz_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

>>> sv/density_matrix_kraus_step_unit.sv
// each accepted item runs two matrix products, each of 8 complex mac steps,
// one magnitude step, 6 bit-length search steps and one shift, then the result
// is loaded into the output register once that register is free
// a new item is accepted only in the idle state, after the previous result is
// loaded, since the single complex multiplier serves every mac step; the next
// item is taken while the previous result waits in the output register
// synchronous reset loads rho = diag(0,1), exponent 0 and the operator reset values
module density_matrix_kraus_step_unit #(
  parameter int MANTISSA_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmks_pkg::ADDR_W-1:0]  paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         jump_taken,
  input  logic                         restart,
  input  logic                         final_step,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  trace_mantissa,
  output logic signed [15:0]           trace_exponent,
  output logic                         jumped,
  output logic                         trajectory_end
);
  import dmks_pkg::*;

  op_bank_t cfg;
  cmd_t     cmd;
  stat_t    stat;

  assign pready = 1'b1;
  assign prdata = cfg[paddr[5:3]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < REG_COUNT; n++) begin
        cfg[n] <= (n == int'(REG_NOJUMP_M00) || n == int'(REG_NOJUMP_M11)) ? OP_ONE : 64'd0;
      end
    end else if (psel && penable && pwrite) begin
      cfg[paddr[5:3]] <= pwdata;
    end
  end

  dmks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dmks_datapath #(.MANTISSA_BITS(MANTISSA_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg            (cfg),
    .jump_taken     (jump_taken),
    .restart        (restart),
    .final_step     (final_step),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .trace_mantissa (trace_mantissa),
    .trace_exponent (trace_exponent),
    .jumped         (jumped),
    .trajectory_end (trajectory_end)
  );

endmodule

>>> sv/dmks_ctrl.sv
// sequencer for the two matrix products, renormalization and result hand-off
// depends on dmks_pkg
module dmks_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  dmks_pkg::stat_t stat,
  output dmks_pkg::cmd_t  cmd
);
  import dmks_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_NORM, S_LZ, S_SHIFT, S_OUT} state_t;

  state_t     state;
  logic [2:0] idx;
  logic [2:0] lzs;
  logic       pass;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.start   = (state == S_IDLE) && in_valid;
    cmd.mac     = (state == S_MAC);
    cmd.norm    = (state == S_NORM);
    cmd.lz      = (state == S_LZ);
    cmd.shift   = (state == S_SHIFT);
    cmd.capture = (state == S_OUT) && stat.out_free;
    cmd.pass    = pass;
    cmd.idx     = idx;
    cmd.lz_step = lzs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      lzs   <= '0;
      pass  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MAC;
            idx   <= '0;
            pass  <= 1'b0;
          end
        end
        S_MAC: begin
          idx <= idx + 3'd1;
          if (idx == 3'd7) state <= S_NORM;
        end
        S_NORM: begin
          lzs   <= '0;
          state <= S_LZ;
        end
        S_LZ: begin
          lzs <= lzs + 3'd1;
          if (lzs == 3'd5) state <= S_SHIFT;
        end
        S_SHIFT: begin
          idx <= '0;
          if (!pass) begin
            pass  <= 1'b1;
            state <= S_MAC;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/dmks_datapath.sv
// matrix state, complex multiply-accumulate, block exponent renormalization
// and the output register; depends on dmks_pkg
module dmks_datapath #(
  parameter int MANTISSA_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  dmks_pkg::cmd_t     cmd,
  output dmks_pkg::stat_t    stat,
  input  dmks_pkg::op_bank_t cfg,
  input  logic               jump_taken,
  input  logic               restart,
  input  logic               final_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        trace_mantissa,
  output logic signed [15:0] trace_exponent,
  output logic               jumped,
  output logic               trajectory_end
);
  import dmks_pkg::*;

  localparam int GUARD = 32 - MANTISSA_BITS;
  localparam logic [63:0] KEEP_MASK = ~((64'd1 << GUARD) - 64'd1);

  logic                jump_q, final_q;
  logic signed [31:0]  rho_re [4];
  logic signed [31:0]  rho_im [4];
  logic signed [31:0]  t_re [4];
  logic signed [31:0]  t_im [4];
  logic signed [63:0]  acc_re [4];
  logic signed [63:0]  acc_im [4];
  logic [63:0]         lzval;
  logic [6:0]          lzlen;
  logic signed [15:0]  expo;

  logic signed [31:0]  a_re [4];
  logic signed [31:0]  a_im [4];
  logic [1:0]          ent, xi, yi, hi;
  logic                kk;
  logic signed [32:0]  xr, xm, yr, ym;
  logic signed [65:0]  p_rr, p_ii, p_ri, p_ir;
  logic signed [63:0]  term_re, term_im;
  logic [63:0]         orv;
  logic [6:0]          len_fin;
  logic signed [7:0]   sh;
  logic signed [17:0]  e_sum;
  logic signed [15:0]  e_new;
  logic signed [32:0]  tr;

  assign stat.out_free = !out_valid || !out_stall;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      a_re[n] = jump_q ? cfg[REG_JUMP_M00 + n][63:32] : cfg[REG_NOJUMP_M00 + n][63:32];
      a_im[n] = jump_q ? cfg[REG_JUMP_M00 + n][31:0]  : cfg[REG_NOJUMP_M00 + n][31:0];
    end
  end

  // entry (i,j) sums over k: x[i,k] * y[k,j]
  assign ent = cmd.idx[2:1];
  assign kk  = cmd.idx[0];
  assign xi  = {ent[1], kk};
  assign yi  = {kk, ent[0]};
  assign hi  = {ent[0], kk};

  always_comb begin
    if (!cmd.pass) begin
      xr = 33'(a_re[xi]);
      xm = 33'(a_im[xi]);
      yr = 33'(rho_re[yi]);
      ym = 33'(rho_im[yi]);
    end else begin
      xr = 33'(t_re[xi]);
      xm = 33'(t_im[xi]);
      yr = 33'(a_re[hi]);
      ym = -33'(a_im[hi]);
    end
    p_rr = xr * yr;
    p_ii = xm * ym;
    p_ri = xr * ym;
    p_ir = xm * yr;
    term_re = 64'(p_rr >>> 2) - 64'(p_ii >>> 2);
    term_im = 64'(p_ri >>> 2) + 64'(p_ir >>> 2);
  end

  // bit length of the largest magnitude equals that of the or of all magnitudes
  always_comb begin
    orv = '0;
    for (int n = 0; n < 4; n++) begin
      orv = orv | (acc_re[n] < 0 ? 64'(-acc_re[n]) : 64'(acc_re[n]));
      orv = orv | (acc_im[n] < 0 ? 64'(-acc_im[n]) : 64'(acc_im[n]));
    end
  end

  assign len_fin = lzlen + 7'(lzval[0]);
  assign sh      = $signed({1'b0, len_fin}) - 8'sd30;
  assign e_sum   = 18'(expo) + 18'(sh) - 18'(EXP_BIAS);

  always_comb begin
    if (e_sum > 18'sd32767) e_new = 16'sh7fff;
    else if (e_sum < -18'sd32768) e_new = 16'sh8000;
    else e_new = e_sum[15:0];
  end

  function automatic logic signed [31:0] renorm(input logic signed [63:0] v,
                                                input logic signed [7:0] s);
    logic signed [63:0] r;
    logic [7:0]         ns;
    ns = 8'(-s);
    if (s >= 0) r = v >>> s[5:0];
    else r = v <<< ns[5:0];
    r = r & KEEP_MASK;
    return r[31:0];
  endfunction

  assign tr = 33'(rho_re[0]) + 33'(rho_re[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      expo      <= '0;
      for (int n = 0; n < 4; n++) begin
        rho_re[n] <= (n == 3) ? Q30_ONE : 32'sd0;
        rho_im[n] <= '0;
      end
    end else begin
      if (cmd.start) begin
        jump_q  <= jump_taken;
        final_q <= final_step;
        if (restart) begin
          expo <= '0;
          for (int n = 0; n < 4; n++) begin
            rho_re[n] <= (n == 3) ? Q30_ONE : 32'sd0;
            rho_im[n] <= '0;
          end
        end
      end
      if (cmd.mac) begin
        if (!kk) begin
          acc_re[ent] <= term_re;
          acc_im[ent] <= term_im;
        end else begin
          acc_re[ent] <= acc_re[ent] + term_re;
          acc_im[ent] <= acc_im[ent] + term_im;
        end
      end
      if (cmd.norm) begin
        lzval <= orv;
        lzlen <= '0;
      end
      if (cmd.lz) begin
        case (cmd.lz_step)
          3'd0: if (lzval[63:32] != 0) begin lzval <= lzval >> 32; lzlen <= lzlen + 7'd32; end
          3'd1: if (lzval[31:16] != 0) begin lzval <= lzval >> 16; lzlen <= lzlen + 7'd16; end
          3'd2: if (lzval[15:8] != 0) begin lzval <= lzval >> 8; lzlen <= lzlen + 7'd8; end
          3'd3: if (lzval[7:4] != 0) begin lzval <= lzval >> 4; lzlen <= lzlen + 7'd4; end
          3'd4: if (lzval[3:2] != 0) begin lzval <= lzval >> 2; lzlen <= lzlen + 7'd2; end
          3'd5: if (lzval[1] != 0) begin lzval <= lzval >> 1; lzlen <= lzlen + 7'd1; end
          default: ;
        endcase
      end
      if (cmd.shift) begin
        // all-zero product leaves the exponent alone
        if (len_fin != 0) expo <= e_new;
        for (int n = 0; n < 4; n++) begin
          if (!cmd.pass) begin
            t_re[n] <= (len_fin == 0) ? 32'sd0 : renorm(acc_re[n], sh);
            t_im[n] <= (len_fin == 0) ? 32'sd0 : renorm(acc_im[n], sh);
          end else begin
            rho_re[n] <= (len_fin == 0) ? 32'sd0 : renorm(acc_re[n], sh);
            rho_im[n] <= (len_fin == 0) ? 32'sd0 : renorm(acc_im[n], sh);
          end
        end
      end
      if (cmd.capture) begin
        out_valid      <= 1'b1;
        trace_mantissa <= tr[32] ? 32'd0 : tr[31:0];
        trace_exponent <= expo;
        jumped         <= jump_q;
        trajectory_end <= final_q;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
